// File: src/lfps_pkg.sv
// ----------------------------------------------------------------------------
// lfps_pkg
// Shared constants, codes and command/status types of the steering core.
// ----------------------------------------------------------------------------
package lfps_pkg;

    localparam int ERROR_FRAC_BITS = 8;
    localparam int SECTION_BITS    = 16;
    localparam int GAIN_FRAC_BITS  = 8;
    localparam int CORR_FRAC_BITS  = GAIN_FRAC_BITS + ERROR_FRAC_BITS;

    localparam int ERR_W   = 14;
    localparam int PREV_W  = 16;
    localparam int ACC_W   = 17;
    localparam int DELTA_W = 17;
    localparam int SPEED_W = 10;
    localparam int GAIN_W  = 16;
    localparam int DT_W    = 16;
    localparam int SUM_W   = 50;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_SPEED   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_SPEED = 3'd4;

    localparam logic [1:0] OP_STEER = 2'd0;
    localparam logic [1:0] OP_FIXED = 2'd1;
    localparam logic [1:0] OP_FIND  = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    localparam int CORR_LIMIT      = 510;
    localparam int FIXED_BASE      = 120;
    localparam int US_PER_MS       = 1000;
    localparam int ACC_MAX         = 65535;
    localparam int ACC_MIN         = -65536;
    localparam int UNIT            = 1 << ERROR_FRAC_BITS;

    // divider: 58-bit unsigned dividend, 17-bit divisor
    localparam int DIV_N_W   = 58;
    localparam int DIV_D_W   = 17;
    localparam int DIV_CNT_W = 6;

    // divide by 1000: 48-bit dividend in 16-bit digits, reciprocal multiply
    localparam int D1K_N_W    = 48;
    localparam int D1K_DIG_W  = 16;
    localparam int D1K_DIGITS = D1K_N_W / D1K_DIG_W;
    localparam int D1K_R_W    = 10;
    localparam int D1K_V_W    = D1K_R_W + D1K_DIG_W;
    localparam int D1K_M_W    = 27;
    localparam int D1K_P_W    = D1K_V_W + D1K_M_W;
    localparam int D1K_SHIFT  = 36;
    localparam int D1K_RECIP  = 68719477;

    typedef struct packed {
        logic load;      // latch item and run section tracking + delta
        logic mul_p;     // P product
        logic mul_i1;    // gain_i * acc
        logic mul_i2;    // (gain_i*acc) * E
        logic mul_d1;    // gain_d * delta
        logic mul_d2;    // (gain_d*delta) * 1000
        logic div_i;     // start divide by 1000 for I
        logic div_d;     // start divider for D
        logic finish;    // sum, clamp, steer and register result
    } lfps_cmd_t;

    typedef struct packed {
        logic div_busy;
    } lfps_sts_t;

endpackage

// File: src/lfps_if.sv
// ----------------------------------------------------------------------------
// lfps_in_if / lfps_out_if
// Valid/ready request channels of the steering core.
// ----------------------------------------------------------------------------
interface lfps_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         operation;
    logic signed [13:0] error;
    logic [15:0]        elapsed_us;
    logic               side;
    modport source (output valid, operation, error, elapsed_us, side, input ready);
    modport sink (input valid, operation, error, elapsed_us, side, output ready);
endinterface

interface lfps_out_if;
    logic               valid;
    logic               ready;
    logic signed [9:0]  right_speed;
    logic signed [9:0]  left_speed;
    logic [15:0]        section;
    logic               on_curve;
    modport source (output valid, right_speed, left_speed, section, on_curve,
                    input ready);
    modport sink (input valid, right_speed, left_speed, section, on_curve,
                  output ready);
endinterface

// File: src/line_follower_pid_steering_core.sv
// ----------------------------------------------------------------------------
// line_follower_pid_steering_core
// Latency from accept to result valid is set mostly by the 58-step pass of
// the bit-serial divider for the D term; an ignored op goes straight to output.
// One request in flight; a new request is accepted only in the idle state.
// Reset: rst_n clears gains, speeds, PID and section state asynchronously.
// ----------------------------------------------------------------------------
module line_follower_pid_steering_core
    import lfps_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    lfps_in_if.sink               in_ch,
    lfps_out_if.source            out_ch
);

    lfps_cmd_t cmd;
    lfps_sts_t sts;

    lfps_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_ch.valid),
        .in_ready   (in_ch.ready),
        .out_valid  (out_ch.valid),
        .out_ready  (out_ch.ready),
        .op_ignored (in_ch.operation == OP_NONE),
        .cmd        (cmd),
        .sts        (sts)
    );

    lfps_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_operation  (in_ch.operation),
        .in_error      (in_ch.error),
        .in_elapsed_us (in_ch.elapsed_us),
        .in_side       (in_ch.side),
        .right_speed   (out_ch.right_speed),
        .left_speed    (out_ch.left_speed),
        .section       (out_ch.section),
        .on_curve      (out_ch.on_curve)
    );

endmodule

// File: src/lfps_div.sv
// ----------------------------------------------------------------------------
// lfps_div
// Restoring unsigned divider, one quotient bit per cycle, and a divide by
// 1000 unit that works one 16-bit digit at a time, digit estimate then remainder.
// ----------------------------------------------------------------------------
module lfps_div
    import lfps_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [DIV_N_W-1:0] dividend,
    input  logic [DIV_D_W-1:0] divisor,
    output logic               busy,
    output logic [DIV_N_W-1:0] quotient
);

    logic [DIV_N_W-1:0]   quo_reg, quo_next;
    logic [DIV_D_W-1:0]   rem_reg, rem_next;
    logic [DIV_D_W-1:0]   dvs_reg, dvs_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic [DIV_D_W:0]     trial;

    // shift in one dividend bit, subtract if it fits
    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {rem_reg, quo_reg[DIV_N_W-1]};
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = DIV_CNT_W'(DIV_N_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = DIV_D_W'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[DIV_N_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DIV_D_W-1:0];
                quo_next = {quo_reg[DIV_N_W-2:0], 1'b0};
            end
            if (cnt_reg == '0)
                busy_next = 1'b0;
            else
                cnt_next = cnt_reg - 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

module lfps_div1000
    import lfps_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [D1K_N_W-1:0] dividend,
    output logic               busy,
    output logic [D1K_N_W-1:0] quotient
);

    logic [D1K_N_W-1:0]   num_reg, num_next;
    logic [D1K_N_W-1:0]   quo_reg, quo_next;
    logic [D1K_R_W-1:0]   rem_reg, rem_next;
    logic [D1K_DIG_W-1:0] qd_reg, qd_next;
    logic [1:0]           cnt_reg, cnt_next;
    logic                 phase_reg, phase_next;
    logic                 busy_reg, busy_next;
    logic [D1K_V_W-1:0]   v;
    logic [D1K_P_W-1:0]   prod;
    logic [D1K_V_W-1:0]   back;

    // partial remainder and next digit; digit from reciprocal, then remainder
    always_comb
    begin
        v    = {rem_reg, num_reg[D1K_N_W-1 -: D1K_DIG_W]};
        prod = D1K_P_W'(v) * D1K_P_W'(D1K_RECIP);
        back = D1K_V_W'(qd_reg) * D1K_V_W'(US_PER_MS);

        num_next   = num_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        qd_next    = qd_reg;
        cnt_next   = cnt_reg;
        phase_next = phase_reg;
        busy_next  = busy_reg;
        if (start)
        begin
            num_next   = dividend;
            quo_next   = '0;
            rem_next   = '0;
            cnt_next   = '0;
            phase_next = 1'b0;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!phase_reg)
            begin
                qd_next    = prod[D1K_SHIFT +: D1K_DIG_W];
                phase_next = 1'b1;
            end
            else
            begin
                rem_next   = D1K_R_W'(v - back);
                quo_next   = {quo_reg[D1K_N_W-D1K_DIG_W-1:0], qd_reg};
                num_next   = num_reg << D1K_DIG_W;
                phase_next = 1'b0;
                if (cnt_reg == 2'(D1K_DIGITS - 1))
                    busy_next = 1'b0;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            cnt_reg   <= '0;
            phase_reg <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            cnt_reg   <= cnt_next;
            phase_reg <= phase_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        qd_reg  <= qd_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

// File: src/lfps_datapath.sv
// ----------------------------------------------------------------------------
// lfps_datapath
// Section tracking, PID terms over a shared multiplier and two dividers,
// clamp and wheel speed mapping.
// ----------------------------------------------------------------------------
module lfps_datapath
    import lfps_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  lfps_cmd_t                 cmd,
    output lfps_sts_t                 sts,
    input  logic                      cfg_we,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data,
    input  logic [1:0]                in_operation,
    input  logic signed [ERR_W-1:0]   in_error,
    input  logic [DT_W-1:0]           in_elapsed_us,
    input  logic                      in_side,
    output logic signed [SPEED_W-1:0] right_speed,
    output logic signed [SPEED_W-1:0] left_speed,
    output logic [15:0]               section,
    output logic                      on_curve
);

    // configuration
    logic [GAIN_W-1:0]         gain_p_reg, gain_i_reg, gain_d_reg;
    logic [8:0]                top_speed_reg;
    logic signed [SPEED_W-1:0] floor_speed_reg;

    // persistent state
    logic signed [PREV_W-1:0]  prev_err_reg, prev_err_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic signed [PREV_W-1:0]  lce_reg, lce_next;
    logic [SECTION_BITS-1:0]   sec_reg, sec_next;
    logic                      curve_reg, curve_next;

    // per item
    logic [1:0]                op_reg;
    logic [DT_W-1:0]           e_reg;
    logic signed [PREV_W-1:0]  err_reg;
    logic signed [DELTA_W-1:0] delta_reg;
    logic signed [SUM_W-1:0]   p_reg, i_reg;
    logic signed [SUM_W-1:0]   prod_reg;
    logic signed [SPEED_W-1:0] right_reg, left_reg;
    logic signed [SPEED_W-1:0] right_nx, left_nx;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg      <= '0;
            gain_i_reg      <= '0;
            gain_d_reg      <= '0;
            top_speed_reg   <= '0;
            floor_speed_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_GAIN_P:      gain_p_reg      <= cfg_data;
                CFG_GAIN_I:      gain_i_reg      <= cfg_data;
                CFG_GAIN_D:      gain_d_reg      <= cfg_data;
                CFG_TOP_SPEED:   top_speed_reg   <= cfg_data[8:0];
                CFG_FLOOR_SPEED: floor_speed_reg <= cfg_data[SPEED_W-1:0];
                default: ;
            endcase
        end
    end

    // load stage: used error, section tracking, delta and accumulator
    logic signed [PREV_W-1:0]  err_used;
    logic [PREV_W-1:0]         mag_err, mag_lce, mag_lce_upd;
    logic signed [PREV_W-1:0]  lce_upd;
    logic                      advance;
    logic signed [DELTA_W-1:0] delta;
    logic signed [ACC_W+1:0]   acc_sum;
    logic signed [ACC_W-1:0]   acc_sat;

    always_comb
    begin
        err_used = PREV_W'(in_error);
        mag_err  = err_used[PREV_W-1] ? PREV_W'(-err_used) : err_used;
        if (in_operation == OP_FIND && mag_err > PREV_W'(10 * UNIT) && !in_side)
            err_used = -err_used;
        mag_lce     = lce_reg[PREV_W-1] ? PREV_W'(-lce_reg) : lce_reg;
        lce_upd     = (mag_err > mag_lce) ? err_used : lce_reg;
        mag_lce_upd = lce_upd[PREV_W-1] ? PREV_W'(-lce_upd) : lce_upd;
        advance = 1'b0;
        if (!curve_reg && mag_err > PREV_W'(5 * UNIT))
            advance = 1'b1;
        else if (curve_reg && {mag_err, 1'b0} < (PREV_W+1)'(UNIT)
                 && mag_lce_upd >= PREV_W'(3 * UNIT))
            advance = 1'b1;

        delta   = DELTA_W'(err_used) - DELTA_W'(prev_err_reg);
        acc_sum = (ACC_W+2)'(acc_reg) + (ACC_W+2)'(delta);
        if (acc_sum > (ACC_W+2)'(ACC_MAX))
            acc_sat = ACC_W'(ACC_MAX);
        else if (acc_sum < (ACC_W+2)'(ACC_MIN))
            acc_sat = ACC_W'(ACC_MIN);
        else
            acc_sat = acc_sum[ACC_W-1:0];
        if ((acc_sat <= 0 && delta >= 0) || (acc_sat >= 0 && delta <= 0))
            acc_sat = '0;

        prev_err_next = prev_err_reg;
        acc_next      = acc_reg;
        lce_next      = lce_reg;
        sec_next      = sec_reg;
        curve_next    = curve_reg;
        if (cmd.load && in_operation != OP_NONE)
        begin
            prev_err_next = err_used;
            acc_next      = acc_sat;
            if (in_operation == OP_STEER)
            begin
                lce_next = lce_upd;
                if (advance)
                begin
                    sec_next   = sec_reg + 1'b1;
                    lce_next   = curve_reg ? '0 : prev_err_reg;
                    curve_next = !curve_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_err_reg <= '0;
            acc_reg      <= '0;
            lce_reg      <= '0;
            sec_reg      <= '0;
            curve_reg    <= 1'b0;
            op_reg       <= '0;
        end
        else
        begin
            prev_err_reg <= prev_err_next;
            acc_reg      <= acc_next;
            lce_reg      <= lce_next;
            sec_reg      <= sec_next;
            curve_reg    <= curve_next;
            if (cmd.load)
                op_reg <= in_operation;
        end
    end

    // shared multiplier: operand select, one product registered per cycle while a multiply command is set
    logic signed [32:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [50:0] mul_y;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (cmd.mul_p)
        begin
            mul_a = 33'(signed'({1'b0, gain_p_reg}));
            mul_b = 18'(err_reg);
        end
        else if (cmd.mul_i1)
        begin
            mul_a = 33'(signed'({1'b0, gain_i_reg}));
            mul_b = 18'(acc_reg);
        end
        else if (cmd.mul_i2)
        begin
            mul_a = prod_reg[32:0];
            mul_b = 18'(signed'({1'b0, e_reg}));
        end
        else if (cmd.mul_d1)
        begin
            mul_a = 33'(signed'({1'b0, gain_d_reg}));
            mul_b = 18'(delta_reg);
        end
        else if (cmd.mul_d2)
        begin
            mul_a = prod_reg[32:0];
            mul_b = 18'(US_PER_MS);
        end
        mul_y = mul_a * mul_b;
    end

    // dividers, sign-magnitude around unsigned cores
    logic               div_start, div_busy;
    logic [DIV_N_W-1:0] div_n, div_q;
    logic [DIV_D_W-1:0] div_dv;
    logic               div_neg_reg;
    logic               d1k_busy;
    logic [D1K_N_W-1:0] d1k_q;
    logic               i_neg_reg;
    logic [SUM_W-1:0]   prod_mag;

    assign prod_mag  = prod_reg[SUM_W-1] ? SUM_W'(-prod_reg) : SUM_W'(prod_reg);
    assign div_start = cmd.div_d;
    assign div_n     = DIV_N_W'(prod_mag);
    assign div_dv    = DIV_D_W'(e_reg);

    lfps_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_n),
        .divisor  (div_dv),
        .busy     (div_busy),
        .quotient (div_q)
    );

    lfps_div1000 u_div1000 (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_i),
        .dividend (D1K_N_W'(prod_mag)),
        .busy     (d1k_busy),
        .quotient (d1k_q)
    );

    assign sts.div_busy = div_busy | d1k_busy;

    logic signed [SUM_W-1:0] div_res, i_res;
    assign div_res = div_neg_reg ? -SUM_W'(div_q) : SUM_W'(div_q);
    assign i_res   = i_neg_reg ? -SUM_W'(d1k_q) : SUM_W'(d1k_q);

    // item latch, product register, term registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            err_reg   <= err_used;
            delta_reg <= delta;
            e_reg     <= (in_elapsed_us == '0) ? DT_W'(US_PER_MS) : in_elapsed_us;
        end
        if (cmd.mul_p | cmd.mul_i1 | cmd.mul_i2 | cmd.mul_d1 | cmd.mul_d2)
            prod_reg <= SUM_W'(mul_y);
        if (cmd.mul_p)
            p_reg <= SUM_W'(mul_y);
        if (cmd.div_i)
            i_neg_reg <= prod_reg[SUM_W-1];
        if (div_start)
            div_neg_reg <= prod_reg[SUM_W-1];
        if (cmd.div_d)
            i_reg <= i_res;
        if (cmd.finish)
        begin
            right_reg <= right_nx;
            left_reg  <= left_nx;
        end
    end

    // sum, clamp, truncate toward zero, wheel speeds
    logic signed [SUM_W-1:0]   sum, sum_c;
    logic [SUM_W-1:0]          sum_mag;
    logic signed [SPEED_W-1:0] corr;
    logic signed [SPEED_W+1:0] base, v;
    localparam logic signed [SUM_W-1:0] LIM = SUM_W'(CORR_LIMIT) <<< CORR_FRAC_BITS;

    always_comb
    begin
        sum = p_reg + i_reg + div_res;
        if (sum > LIM)
            sum_c = LIM;
        else if (sum < -LIM)
            sum_c = -LIM;
        else
            sum_c = sum;
        sum_mag = sum_c[SUM_W-1] ? SUM_W'(-sum_c) : SUM_W'(sum_c);
        corr    = SPEED_W'(sum_mag >> CORR_FRAC_BITS);
        if (sum_c[SUM_W-1])
            corr = -corr;
        base = (op_reg == OP_STEER) ? (SPEED_W+2)'(top_speed_reg)
                                    : (SPEED_W+2)'(FIXED_BASE);
        right_nx = '0;
        left_nx  = '0;
        v        = '0;
        case (op_reg)
            OP_STEER, OP_FIXED:
            begin
                if (!corr[SPEED_W-1])
                begin
                    v = base - (SPEED_W+2)'(corr);
                    if (v < (SPEED_W+2)'(floor_speed_reg))
                        v = (SPEED_W+2)'(floor_speed_reg);
                    right_nx = SPEED_W'(v);
                    left_nx  = SPEED_W'(base);
                end
                else
                begin
                    v = base + (SPEED_W+2)'(corr);
                    if (v < (SPEED_W+2)'(floor_speed_reg))
                        v = (SPEED_W+2)'(floor_speed_reg);
                    right_nx = SPEED_W'(base);
                    left_nx  = SPEED_W'(v);
                end
            end
            OP_FIND:
            begin
                if (corr[SPEED_W-1])
                    right_nx = corr;
                else
                    left_nx = -corr;
            end
            default:
            begin
                right_nx = '0;
                left_nx  = '0;
            end
        endcase
    end

    assign right_speed = (op_reg == OP_NONE) ? '0 : right_reg;
    assign left_speed  = (op_reg == OP_NONE) ? '0 : left_reg;
    assign section     = sec_reg[15:0];
    assign on_curve    = curve_reg;

endmodule

// File: src/lfps_ctrl.sv
// ----------------------------------------------------------------------------
// lfps_ctrl
// Sequencer: accepts a request, steps the multiplier and dividers, and holds
// the result until it is taken.
// ----------------------------------------------------------------------------
module lfps_ctrl
    import lfps_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  logic      op_ignored,
    output lfps_cmd_t cmd,
    input  lfps_sts_t sts
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_MP    = 4'd1;
    localparam logic [3:0] ST_MI1   = 4'd2;
    localparam logic [3:0] ST_MI2   = 4'd3;
    localparam logic [3:0] ST_DI    = 4'd4;
    localparam logic [3:0] ST_WI    = 4'd5;
    localparam logic [3:0] ST_MD1   = 4'd6;
    localparam logic [3:0] ST_MD2   = 4'd7;
    localparam logic [3:0] ST_DD    = 4'd8;
    localparam logic [3:0] ST_WD    = 4'd9;
    localparam logic [3:0] ST_DONE  = 4'd10;
    localparam logic [3:0] ST_OUT   = 4'd11;

    logic [3:0] state_reg, state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = op_ignored ? ST_OUT : ST_MP;
                end
            end
            ST_MP:  begin cmd.mul_p  = 1'b1; state_next = ST_MI1; end
            ST_MI1: begin cmd.mul_i1 = 1'b1; state_next = ST_MI2; end
            ST_MI2: begin cmd.mul_i2 = 1'b1; state_next = ST_DI;  end
            ST_DI:  begin cmd.div_i  = 1'b1; state_next = ST_WI;  end
            ST_WI:
            begin
                if (!sts.div_busy)
                begin
                    cmd.mul_d1 = 1'b1;
                    state_next = ST_MD1;
                end
            end
            // i term is captured when the d division starts
            ST_MD1: begin cmd.mul_d2 = 1'b1; state_next = ST_MD2; end
            ST_MD2: begin state_next = ST_DD; end
            ST_DD:  begin cmd.div_d  = 1'b1; state_next = ST_WD;  end
            ST_WD:
            begin
                if (!sts.div_busy)
                    state_next = ST_DONE;
            end
            ST_DONE: begin cmd.finish = 1'b1; state_next = ST_OUT; end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule
